### design/air_pressure_hysteresis_guard_assert.svh
// ----------------------------------------------------------------------------
// air pressure hysteresis guard assertion macros
// concurrent checks clocked on clk_i, off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef AIR_PRESSURE_HYSTERESIS_GUARD_ASSERT_SVH
`define AIR_PRESSURE_HYSTERESIS_GUARD_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define APG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// antecedent implies consequent in the next cycle
`define APG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### design/apg_pkg.sv
// ----------------------------------------------------------------------------
// apg_pkg
// types and constants shared by the air pressure hysteresis guard
// ----------------------------------------------------------------------------
package apg_pkg;

  localparam int unsigned CfgIdxW = 4;

  // register reset values
  localparam logic [14:0] DefMinRst     = 15'd256;
  localparam logic [14:0] DefMaxRst     = 15'd512;
  localparam logic [14:0] DefReliefRst  = 15'd640;
  localparam logic [14:0] CloseLevelRst = 15'd576;
  localparam logic [15:0] BattLowRst    = 16'd3300;
  localparam logic [31:0] TimeoutRst    = 32'd5000;
  localparam logic [7:0]  ErrLimitRst   = 8'd5;
  localparam logic [15:0] SpeedRst      = 16'd32768;
  localparam logic [7:0]  ErrCntMax     = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEF_MIN     = 4'd0,
    CFG_DEF_MAX     = 4'd1,
    CFG_DEF_RELIEF  = 4'd2,
    CFG_CLOSE_LEVEL = 4'd3,
    CFG_BATT_LOW    = 4'd4,
    CFG_TIMEOUT     = 4'd5,
    CFG_ERR_LIMIT   = 4'd6,
    CFG_SPEED       = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic               action;
    logic [31:0]        now_ms;
    logic signed [15:0] pressure;
    logic [15:0]        battery_mv;
    logic               load_thresholds;
    logic [14:0]        new_pressure_min;
    logic [14:0]        new_pressure_max;
    logic [14:0]        new_pressure_relief;
  } item_t;

  typedef struct packed {
    logic        compressor_running;
    logic        valve_opened;
    logic        fault;
    logic [15:0] speed_command;
    logic        defaults_restored;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [14:0] default_pressure_min;
    logic [14:0] default_pressure_max;
    logic [14:0] default_pressure_relief;
    logic [14:0] relief_close_level;
    logic [15:0] battery_low_mv;
    logic [31:0] link_timeout_ms;
    logic [7:0]  sensor_error_limit;
    logic [15:0] compressor_speed;
  } cfg_t;

  typedef struct packed {
    logic [14:0] active_min;
    logic [14:0] active_max;
    logic [14:0] active_relief;
    logic        compressor;
    logic        valve;
    logic        fault;
    logic        packet_seen;
    logic [7:0]  err_cnt;
    logic [31:0] last_packet_ms;
  } state_t;

endpackage

### design/apg_if.sv
// ----------------------------------------------------------------------------
// apg_if
// valid/ready channels for items, results and register writes
// ----------------------------------------------------------------------------
interface apg_item_if import apg_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface apg_result_if import apg_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface apg_cfg_if import apg_pkg::*; ();
  logic    valid;
  logic    ready;
  cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/air_pressure_hysteresis_guard.sv
// ----------------------------------------------------------------------------
// air_pressure_hysteresis_guard
// pipeline: item transaction, input reg, result reg, result transaction
// throughput: 1 item per cycle unless a result waits unread with result_o.ready low
// reset: registers take their default values, thresholds load the defaults,
// compressor, valve, fault, error count and packet timer clear; pipe empties
// bang-bang air pump controller with relief valve and sensor fault guard
// ----------------------------------------------------------------------------
module air_pressure_hysteresis_guard import apg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  apg_cfg_if.sink      cfg_i,
  apg_item_if.sink     item_i,
  apg_result_if.source result_o
);

  // configuration registers, always ready
  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.default_pressure_min    <= DefMinRst;
      cfg_q.default_pressure_max    <= DefMaxRst;
      cfg_q.default_pressure_relief <= DefReliefRst;
      cfg_q.relief_close_level      <= CloseLevelRst;
      cfg_q.battery_low_mv          <= BattLowRst;
      cfg_q.link_timeout_ms         <= TimeoutRst;
      cfg_q.sensor_error_limit      <= ErrLimitRst;
      cfg_q.compressor_speed        <= SpeedRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CFG_DEF_MIN:     cfg_q.default_pressure_min    <= cfg_i.data.wdata[14:0];
        CFG_DEF_MAX:     cfg_q.default_pressure_max    <= cfg_i.data.wdata[14:0];
        CFG_DEF_RELIEF:  cfg_q.default_pressure_relief <= cfg_i.data.wdata[14:0];
        CFG_CLOSE_LEVEL: cfg_q.relief_close_level      <= cfg_i.data.wdata[14:0];
        CFG_BATT_LOW:    cfg_q.battery_low_mv          <= cfg_i.data.wdata[15:0];
        CFG_TIMEOUT:     cfg_q.link_timeout_ms         <= cfg_i.data.wdata;
        CFG_ERR_LIMIT:   cfg_q.sensor_error_limit      <= cfg_i.data.wdata[7:0];
        CFG_SPEED:       cfg_q.compressor_speed        <= cfg_i.data.wdata[15:0];
        default: ; // indexes past the register list are dropped
      endcase
    end
  end

  // pipeline control: the whole pipe advances unless a result waits unread
  logic  stg_vld_q;
  item_t stg_item_q;
  logic  res_vld_q;
  result_t res_q;
  logic  advance;
  logic  item_acc;
  logic  step_fire;

  assign advance        = !res_vld_q || result_o.ready;
  assign item_i.ready   = !stg_vld_q || advance;
  assign item_acc       = item_i.valid && item_i.ready;
  assign step_fire      = stg_vld_q && advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else if (item_i.ready) begin
      stg_vld_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      stg_item_q <= item_i.data;
    end
  end

  // controller state, updated once per item as it leaves the input register
  state_t  st_q;
  state_t  st_d;
  result_t res_d;

  apg_step u_step (
    .item_i   (stg_item_q),
    .state_i  (st_q),
    .cfg_i    (cfg_q),
    .state_o  (st_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.active_min     <= DefMinRst;
      st_q.active_max     <= DefMaxRst;
      st_q.active_relief  <= DefReliefRst;
      st_q.compressor     <= 1'b0;
      st_q.valve          <= 1'b0;
      st_q.fault          <= 1'b0;
      st_q.packet_seen    <= 1'b0;
      st_q.err_cnt        <= '0;
      st_q.last_packet_ms <= '0;
    end else if (step_fire) begin
      st_q <= st_d;
    end
  end

  // result register, holds a telemetry word until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= stg_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid = res_vld_q;
  assign result_o.data  = res_q;

  // checks
  `include "air_pressure_hysteresis_guard_assert.svh"

  // the relief path always stops the compressor, so both are never on
  `APG_ASSERT_SAME(a_pump_valve_excl, 1'b1, !(st_q.compressor && st_q.valve))
  // a staged item always lands in the result register
  `APG_ASSERT_NEXT(a_stage_to_result, step_fire, res_vld_q)
  // speed is only commanded while running
  `APG_ASSERT_SAME(a_speed_only_running, res_vld_q && !res_q.compressor_running,
    res_q.speed_command == '0)

endmodule

### design/apg_step.sv
// ----------------------------------------------------------------------------
// apg_step
// next controller state and telemetry for one item
// ----------------------------------------------------------------------------
module apg_step import apg_pkg::*; (
  input  item_t   item_i,
  input  state_t  state_i,
  input  cfg_t    cfg_i,
  output state_t  state_o,
  output result_t result_o
);

  logic [31:0] elapsed;
  logic [7:0]  cnt_inc;
  logic [14:0] p_mag;
  logic        restored;
  state_t      st;

  assign elapsed = item_i.now_ms - state_i.last_packet_ms;
  assign cnt_inc = (state_i.err_cnt != ErrCntMax) ? state_i.err_cnt + 8'd1 : state_i.err_cnt;
  assign p_mag   = item_i.pressure[14:0];

  always_comb begin
    st       = state_i;
    restored = 1'b0;
    if (item_i.action) begin
      st.last_packet_ms = item_i.now_ms;
      st.packet_seen    = 1'b1;
      if (item_i.load_thresholds) begin
        st.active_min    = item_i.new_pressure_min;
        st.active_max    = item_i.new_pressure_max;
        st.active_relief = item_i.new_pressure_relief;
      end
    end else if (item_i.pressure[15]) begin
      // bad sensor reading
      st.err_cnt = cnt_inc;
      if (cnt_inc >= cfg_i.sensor_error_limit) begin
        st.fault      = 1'b1;
        st.compressor = 1'b0;
        st.valve      = 1'b0;
      end
    end else begin
      st.err_cnt = '0;
      if (state_i.packet_seen && (elapsed > cfg_i.link_timeout_ms)) begin
        st.active_min    = cfg_i.default_pressure_min;
        st.active_max    = cfg_i.default_pressure_max;
        st.active_relief = cfg_i.default_pressure_relief;
        restored         = 1'b1;
      end
      st.fault = 1'b0;
      if (p_mag >= st.active_relief) begin
        st.valve      = 1'b1;
        st.compressor = 1'b0;
      end else begin
        if (st.valve && (p_mag <= cfg_i.relief_close_level)) begin
          st.valve = 1'b0;
        end
        if (!st.valve) begin
          if ((p_mag < st.active_min) && !st.compressor) begin
            st.compressor = 1'b1;
          end else if ((p_mag >= st.active_max) && st.compressor) begin
            st.compressor = 1'b0;
          end
        end
        if ((item_i.battery_mv != '0) && (item_i.battery_mv < cfg_i.battery_low_mv)) begin
          st.compressor = 1'b0;
          st.fault      = 1'b1;
        end
      end
    end
  end

  assign state_o                     = st;
  assign result_o.compressor_running = st.compressor;
  assign result_o.valve_opened       = st.valve;
  assign result_o.fault              = st.fault;
  assign result_o.speed_command      = st.compressor ? cfg_i.compressor_speed : '0;
  assign result_o.defaults_restored  = restored;

endmodule

### verif/air_pressure_hysteresis_guard_tb.sv
// ----------------------------------------------------------------------------
// air_pressure_hysteresis_guard_tb
// self-checking bench for the air pump pressure guard: a short directed table
// walks the threshold, relief, battery, sensor fault and comms timeout cases,
// then random sample and packet streams run under several register settings;
// every telemetry transaction is compared against a hand-written value or an in-bench predictor
// ----------------------------------------------------------------------------
module air_pressure_hysteresis_guard_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import apg_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int DrainSlack = 4;
  localparam int MaxReports = 40;

  // register contents right after reset
  localparam cfg_t RegsAtReset = '{
    DefMinRst, DefMaxRst, DefReliefRst, CloseLevelRst,
    BattLowRst, TimeoutRst, ErrLimitRst, SpeedRst
  };

  // one directed row: stimulus plus an optional hand-written telemetry value
  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t want;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  apg_cfg_if    cfg_if ();
  apg_item_if   item_if ();
  apg_result_if res_if ();

  air_pressure_hysteresis_guard dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .item_i   (item_if),
    .result_o (res_if)
  );

  always #6 clk_i = ~clk_i;

  // predictor copy of the registers and the controller state
  cfg_t        cfg_copy;
  logic [14:0] thr_min, thr_max, thr_relief;
  logic        pump_on, relief_open, fault_on, pkt_seen;
  logic [7:0]  bad_run;
  logic [31:0] last_pkt_ms;

  // telemetry still owed by the block, oldest first
  result_t     pending_telemetry[$];
  stim_row_t   directed_rows[$];

  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          stall_left     = 0;
  int          neg_left       = 0;
  bit          steady         = 1'b0;
  logic [31:0] now_tick       = '0;
  result_t     seen_res, want_res;
  cfg_t        phase_cfg;

  // one line per mismatch, printing capped so a broken block stays readable
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("%0t ns mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    end
  endtask

  // next telemetry word for one item, advancing the predictor state
  function automatic result_t guard_step(input item_t it);
    result_t     res;
    int          pv;
    logic [31:0] elapsed;
    logic        restored;
    restored = 1'b0;
    pv       = $signed(it.pressure);
    if (it.action) begin
      // packet from host: restart comms timer, maybe take new thresholds
      last_pkt_ms = it.now_ms;
      pkt_seen    = 1'b1;
      if (it.load_thresholds) begin
        thr_min    = it.new_pressure_min;
        thr_max    = it.new_pressure_max;
        thr_relief = it.new_pressure_relief;
      end
    end else if (pv < 0) begin
      // sensor error: saturating count, fault once the limit is reached
      if (bad_run != ErrCntMax) bad_run++;
      if (bad_run >= cfg_copy.sensor_error_limit) begin
        fault_on    = 1'b1;
        pump_on     = 1'b0;
        relief_open = 1'b0;
      end
    end else begin
      bad_run = '0;
      elapsed = it.now_ms - last_pkt_ms;
      if (pkt_seen && elapsed > cfg_copy.link_timeout_ms) begin
        thr_min    = cfg_copy.default_pressure_min;
        thr_max    = cfg_copy.default_pressure_max;
        thr_relief = cfg_copy.default_pressure_relief;
        restored   = 1'b1;
      end
      fault_on = 1'b0;
      if (pv >= int'(thr_relief)) begin
        // overpressure wins over everything else, battery is not looked at
        relief_open = 1'b1;
        pump_on     = 1'b0;
      end else begin
        if (relief_open && pv <= int'(cfg_copy.relief_close_level)) relief_open = 1'b0;
        if (!relief_open) begin
          if (pv < int'(thr_min) && !pump_on) pump_on = 1'b1;
          else if (pv >= int'(thr_max) && pump_on) pump_on = 1'b0;
        end
        if (it.battery_mv != '0 && it.battery_mv < cfg_copy.battery_low_mv) begin
          pump_on  = 1'b0;
          fault_on = 1'b1;
        end
      end
    end
    res.compressor_running = pump_on;
    res.valve_opened       = relief_open;
    res.fault              = fault_on;
    res.speed_command      = pump_on ? cfg_copy.compressor_speed : '0;
    res.defaults_restored  = restored;
    return res;
  endfunction

  // hand-written telemetry, valid only while the speed register holds its reset value
  function automatic result_t tele(input logic c, input logic v, input logic f,
                                   input logic r);
    result_t res;
    res.compressor_running = c;
    res.valve_opened       = v;
    res.fault              = f;
    res.speed_command      = c ? SpeedRst : '0;
    res.defaults_restored  = r;
    return res;
  endfunction

  function automatic item_t sample_item(input logic [31:0] now, input int p,
                                        input logic [15:0] batt);
    item_t it;
    it                 = '0;
    it.now_ms          = now;
    it.pressure        = p[15:0];
    it.battery_mv      = batt;
    return it;
  endfunction

  function automatic item_t packet_item(input logic [31:0] now, input logic load,
                                        input logic [14:0] mn, input logic [14:0] mx,
                                        input logic [14:0] rl);
    item_t it;
    it                     = '0;
    it.action              = 1'b1;
    it.now_ms              = now;
    it.load_thresholds     = load;
    it.new_pressure_min    = mn;
    it.new_pressure_max    = mx;
    it.new_pressure_relief = rl;
    return it;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random upper bits above the register width, the block must drop them
  function automatic logic [31:0] pad_bits(input logic [31:0] v, input int w);
    logic [31:0] mask;
    mask = (w >= 32) ? '1 : ((32'd1 << w) - 32'd1);
    return (v & mask) | ($urandom() & ~mask);
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    int   lvl;
    c.default_pressure_min    = 15'($urandom_range(0, 800));
    c.default_pressure_max    = c.default_pressure_min + 15'($urandom_range(0, 800));
    c.default_pressure_relief = c.default_pressure_max + 15'($urandom_range(0, 400));
    lvl = int'(c.default_pressure_relief) - int'($urandom_range(0, 200));
    c.relief_close_level      = (lvl < 0) ? '0 : 15'(lvl);
    c.battery_low_mv          = 16'($urandom_range(2000, 4000));
    c.link_timeout_ms         = 32'($urandom_range(50, 5000));
    c.sensor_error_limit      = 8'($urandom_range(1, 8));
    c.compressor_speed        = 16'($urandom());
    return c;
  endfunction

  // random item shaped around the live thresholds, timer and error limit
  function automatic item_t make_random_item();
    item_t it;
    int    pick;
    int    p;
    int    cap;
    it.load_thresholds = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 1)) begin
      it.new_pressure_min    = 15'($urandom_range(0, 600));
      it.new_pressure_max    = it.new_pressure_min + 15'($urandom_range(0, 600));
      it.new_pressure_relief = it.new_pressure_max + 15'($urandom_range(0, 300));
    end else begin
      it.new_pressure_min    = 15'($urandom());
      it.new_pressure_max    = 15'($urandom());
      it.new_pressure_relief = 15'($urandom());
    end

    // battery: unmeasured, right at the low level, or anything
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it.battery_mv = '0;
    end else if (pick < 65) begin
      p = int'(cfg_copy.battery_low_mv) + int'($urandom_range(0, 2)) - 1;
      it.battery_mv = (p < 0) ? '0 : (p > 65535) ? '1 : 16'(p);
    end else begin
      it.battery_mv = 16'($urandom());
    end

    // time base: small steps, the timeout edge, long silence, wild jumps
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      now_tick += 32'($urandom_range(0, 40));
    end else if (pick < 75) begin
      now_tick = last_pkt_ms + cfg_copy.link_timeout_ms + 32'($urandom_range(0, 2)) - 32'd1;
    end else if (pick < 90) begin
      now_tick += 32'($urandom_range(1000, 20000));
    end else begin
      now_tick = $urandom();
    end
    it.now_ms = now_tick;

    // runs of bad samples so the error limit is actually reached
    if (neg_left == 0 && $urandom_range(0, 99) < 4) begin
      cap = int'(cfg_copy.sensor_error_limit) + 2;
      if (cap > 12) cap = 12;
      neg_left = $urandom_range(1, cap);
    end

    if (neg_left > 0) begin
      it.action = 1'b0;
      p = -int'($urandom_range(1, 32768));
      neg_left--;
    end else begin
      it.action = ($urandom_range(0, 99) < 15);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        p = -int'($urandom_range(1, 32768));
      end else if (pick < 55) begin
        case ($urandom_range(0, 3))
          0:       p = int'(thr_min);
          1:       p = int'(thr_max);
          2:       p = int'(thr_relief);
          default: p = int'(cfg_copy.relief_close_level);
        endcase
        p = p + int'($urandom_range(0, 4)) - 2;
        if (p < 0) p = 0;
        if (p > 32767) p = 32767;
      end else if (pick < 75) begin
        p = $urandom_range(0, 1023);
      end else begin
        p = int'($urandom_range(0, 65535)) - 32768;
      end
    end
    it.pressure = p[15:0];
    return it;
  endfunction

  // one item transaction; valid is only dropped when a gap follows
  task automatic push_item(input item_t it, input logic typed, input result_t typed_res);
    int      gap;
    result_t predicted;
    gap = idle_len();
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= it;
    do @(posedge clk_i); while (!item_if.ready);
    predicted = guard_step(it);
    pending_telemetry.push_back(typed ? typed_res : predicted);
  endtask

  // register write transaction, predictor copy follows at the handshake
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] wd);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, wdata: wd};
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_DEF_MIN:     cfg_copy.default_pressure_min    = wd[14:0];
      CFG_DEF_MAX:     cfg_copy.default_pressure_max    = wd[14:0];
      CFG_DEF_RELIEF:  cfg_copy.default_pressure_relief = wd[14:0];
      CFG_CLOSE_LEVEL: cfg_copy.relief_close_level      = wd[14:0];
      CFG_BATT_LOW:    cfg_copy.battery_low_mv          = wd[15:0];
      CFG_TIMEOUT:     cfg_copy.link_timeout_ms         = wd;
      CFG_ERR_LIMIT:   cfg_copy.sensor_error_limit      = wd[7:0];
      CFG_SPEED:       cfg_copy.compressor_speed        = wd[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    while (pending_telemetry.size() != 0) @(posedge clk_i);
    repeat (DrainSlack) @(posedge clk_i);
  endtask

  // block is idle on entry: load every register, then a random stream
  task automatic run_phase(input cfg_t c, input int count, input bit no_idle,
                           input int pause_at);
    steady = no_idle;
    write_reg(CFG_DEF_MIN,     pad_bits(32'(c.default_pressure_min), 15));
    write_reg(CFG_DEF_MAX,     pad_bits(32'(c.default_pressure_max), 15));
    write_reg(CFG_DEF_RELIEF,  pad_bits(32'(c.default_pressure_relief), 15));
    write_reg(CFG_CLOSE_LEVEL, pad_bits(32'(c.relief_close_level), 15));
    write_reg(CFG_BATT_LOW,    pad_bits(32'(c.battery_low_mv), 16));
    write_reg(CFG_TIMEOUT,     c.link_timeout_ms);
    write_reg(CFG_ERR_LIMIT,   pad_bits(32'(c.sensor_error_limit), 8));
    write_reg(CFG_SPEED,       pad_bits(32'(c.compressor_speed), 16));
    // index past the register file must be ignored
    write_reg(4'($urandom_range(2 ** CfgIdxW - 1, int'(CFG_SPEED) + 1)), $urandom());
    cfg_if.valid <= 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) begin
        // hold the sender until every owed telemetry word is back
        item_if.valid <= 1'b0;
        wait_drain();
      end
      push_item(make_random_item(), 1'b0, '0);
    end
    item_if.valid <= 1'b0;
    wait_drain();
    steady = 1'b0;
  endtask

  // result side: random back-pressure and in-order telemetry check
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        seen_res = res_if.data;
        if (pending_telemetry.size() == 0) begin
          report_mismatch("telemetry with nothing pending", 32'(seen_res), '0);
        end else begin
          want_res = pending_telemetry.pop_front();
          if (seen_res.compressor_running !== want_res.compressor_running)
            report_mismatch("compressor_running", 32'(seen_res.compressor_running),
                            32'(want_res.compressor_running));
          if (seen_res.valve_opened !== want_res.valve_opened)
            report_mismatch("valve_opened", 32'(seen_res.valve_opened),
                            32'(want_res.valve_opened));
          if (seen_res.fault !== want_res.fault)
            report_mismatch("fault", 32'(seen_res.fault), 32'(want_res.fault));
          if (seen_res.speed_command !== want_res.speed_command)
            report_mismatch("speed_command", 32'(seen_res.speed_command),
                            32'(want_res.speed_command));
          if (seen_res.defaults_restored !== want_res.defaults_restored)
            report_mismatch("defaults_restored", 32'(seen_res.defaults_restored),
                            32'(want_res.defaults_restored));
        end
      end
      // ready low for a random stretch now and then, no new stretch starts while steady
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
        if ($urandom_range(0, 99) < 20) stall_left = idle_len();
      end
    end
  end

  // watchdog: cycle counter ends a hung run
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL air_pressure_hysteresis_guard");
    $finish;
  end

  initial begin
    // all block inputs known from time zero
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    item_if.valid = 1'b0;
    item_if.data  = '0;
    res_if.ready  = 1'b0;

    // predictor starts from the reset state
    cfg_copy    = RegsAtReset;
    thr_min     = DefMinRst;
    thr_max     = DefMaxRst;
    thr_relief  = DefReliefRst;
    pump_on     = 1'b0;
    relief_open = 1'b0;
    fault_on    = 1'b0;
    pkt_seen    = 1'b0;
    bad_run     = '0;
    last_pkt_ms = '0;

    // directed rows at reset register values
    // start below min, stop at max
    directed_rows.push_back('{sample_item(32'd0, 0, 16'd0), 1'b1, tele(1, 0, 0, 0)});
    directed_rows.push_back('{sample_item(32'd10, 512, 16'd0), 1'b1, tele(0, 0, 0, 0)});
    // full-scale pressure opens relief, valve holds above close level, closes at it
    directed_rows.push_back('{sample_item(32'd11, 32767, 16'hFFFF), 1'b1, tele(0, 1, 0, 0)});
    directed_rows.push_back('{sample_item(32'd12, 600, 16'd0), 1'b0, '0});
    directed_rows.push_back('{sample_item(32'd13, 576, 16'd0), 1'b0, '0});
    // battery just below and at the low level
    directed_rows.push_back('{sample_item(32'd14, 100, 16'd3299), 1'b1, tele(0, 0, 1, 0)});
    directed_rows.push_back('{sample_item(32'd15, 100, 16'd3300), 1'b1, tele(1, 0, 0, 0)});
    // five bad samples in a row: fault on the fifth, sixth keeps it
    for (int i = 0; i < 4; i++)
      directed_rows.push_back('{sample_item(32'd16, -32768, 16'd0), 1'b0, '0});
    directed_rows.push_back('{sample_item(32'd16, -32768, 16'd0), 1'b1, tele(0, 0, 1, 0)});
    directed_rows.push_back('{sample_item(32'd17, -1, 16'd0), 1'b0, '0});
    // good sample clears the fault, no packet yet so no timeout
    directed_rows.push_back('{sample_item(32'd20, 0, 16'd0), 1'b0, '0});
    // packet at tick zero still arms the timer
    directed_rows.push_back('{packet_item(32'd0, 1'b0, '0, '0, '0), 1'b1, tele(1, 0, 0, 0)});
    // elapsed equal to timeout does nothing, one more tick restores defaults
    directed_rows.push_back('{sample_item(32'd5000, 300, 16'd0), 1'b0, '0});
    directed_rows.push_back('{sample_item(32'd5001, 300, 16'd0), 1'b1, tele(1, 0, 0, 1)});
    // extreme thresholds near the top of the tick range
    directed_rows.push_back('{packet_item(32'hFFFF_FFF0, 1'b1, 15'd0, 15'h7FFF, 15'h7FFF),
                              1'b0, '0});
    // tick wraps: under the timeout, then just over it
    directed_rows.push_back('{sample_item(32'h0000_1000, 32766, 16'd0), 1'b0, '0});
    directed_rows.push_back('{sample_item(32'h0000_1380, 32767, 16'd0), 1'b1,
                              tele(0, 1, 0, 1)});
    // inverted thresholds with relief at zero, then a packet that loads nothing
    directed_rows.push_back('{packet_item(32'h0000_2000, 1'b1, 15'h7FFF, 15'd0, 15'd0),
                              1'b0, '0});
    directed_rows.push_back('{sample_item(32'h0000_2001, 0, 16'd0), 1'b0, '0});
    directed_rows.push_back('{packet_item(32'h0000_2002, 1'b0, 15'h7FFF, 15'h7FFF,
                                          15'h7FFF), 1'b0, '0});
    directed_rows.push_back('{sample_item(32'h0000_2003, 0, 16'd1), 1'b0, '0});

    // single reset at the start of the run
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      push_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
    item_if.valid <= 1'b0;
    wait_drain();
    now_tick = 32'h0000_2003;

    // typical settings, opening with a bad-sample flood past counter saturation
    neg_left = 260;
    run_phase(random_cfg(), 300, 1'b0, -1);

    // all registers at zero, back to back with no idling on either side
    run_phase('0, 60, 1'b1, -1);

    // all registers at their maximum
    run_phase('1, 60, 1'b0, -1);

    // unordered default thresholds, sender holds off midway
    phase_cfg = random_cfg();
    phase_cfg.default_pressure_min    = 15'($urandom());
    phase_cfg.default_pressure_max    = 15'($urandom());
    phase_cfg.default_pressure_relief = 15'($urandom());
    run_phase(phase_cfg, 100, 1'b0, 50);

    // back to the reset values
    run_phase(RegsAtReset, 60, 1'b0, -1);

    if (mismatch_count == 0) begin
      $display("PASS air_pressure_hysteresis_guard");
    end else begin
      $display("FAIL air_pressure_hysteresis_guard");
    end
    $finish;
  end

endmodule
